// ===== rtl/wms_pkg.sv =====
package wms_pkg;

	// One decoded message as it arrives
	typedef struct packed {
		logic [31:0] msg_time;
		logic [4:0]  downlink_format;
		logic [23:0] aircraft_address;
		logic [7:0]  nation_id;
	} msg_t;

	// One item of a window record
	typedef struct packed {
		logic [31:0] window_start;
		logic [3:0]  item_kind;
		logic [31:0] count_value;
		logic        last_item;
	} rec_t;

	// Control from the top level to a distinct-value table
	typedef struct packed {
		logic start;
		logic clear;
	} dst_ctrl_t;

	// Record item kinds
	localparam logic [3:0] KIND_TOTAL    = 4'd0;
	localparam logic [3:0] KIND_AIRCRAFT = 4'd12;
	localparam logic [3:0] KIND_NATIONS  = 4'd13;

	localparam int FORMAT_BINS = 11;

	// Register map (word index)
	localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;
	localparam logic [31:0] WINDOW_LENGTH_RESET = 32'd60;

	// Record kind of a reported downlink format; KIND_TOTAL when not reported
	function automatic logic [3:0] format_kind(input logic [4:0] df);
		logic [3:0] k;
		unique case (df)
			5'd0:    k = 4'd1;
			5'd4:    k = 4'd2;
			5'd5:    k = 4'd3;
			5'd11:   k = 4'd4;
			5'd16:   k = 4'd5;
			5'd17:   k = 4'd6;
			5'd18:   k = 4'd7;
			5'd19:   k = 4'd8;
			5'd20:   k = 4'd9;
			5'd21:   k = 4'd10;
			5'd24:   k = 4'd11;
			default: k = KIND_TOTAL;
		endcase
		return k;
	endfunction

endpackage

// ===== rtl/wms_stream_if.sv =====
interface wms_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/windowed_message_statistics_unit.sv =====
// Windowed message statistics.
// msg_ch (sink) takes one decoded message per transfer: time, downlink format,
// aircraft address, nation id. rec_ch (source) gives window records, 14 transfers
// each: total, eleven format counts, distinct aircraft, distinct nations; last_item
// marks the fourteenth. window_length is written over the APB port (index 0).
// The first message opens a window at its own time; a message at or past the
// window end closes it, the record goes out and the window start moves by one
// length, with that message counted in the new window.
// A message's handling time is set by the linear search of the two distinct tables,
// one memory read per cycle each; a hit ends a search early. A closing message also
// loads the record, one item per cycle as the output register frees.
// The output register holds a record item while rec_ch stalls; the block waits
// for it, and then accepts further messages.
// Reset clears the counters, the window and the table fill counts; window_length
// returns to 60. No clearing pass is needed.
module windowed_message_statistics_unit #(
	parameter int AIRCRAFT_SLOTS = 256,
	parameter int NATION_SLOTS   = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	wms_stream_if.sink              msg_ch,
	wms_stream_if.source            rec_ch,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import wms_pkg::*;

	localparam int AC_CNT_W  = $clog2(AIRCRAFT_SLOTS + 1);
	localparam int NAT_CNT_W = $clog2(NATION_SLOTS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_EMIT  = 3'd2;
	localparam logic [2:0] ST_COUNT = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	logic [2:0]  state_q;
	logic [31:0] window_length_q;
	logic [31:0] begin_q;
	logic [31:0] end_q;
	logic        open_q;
	logic [31:0] total_q;
	logic [31:0] bins_q [FORMAT_BINS];
	logic [3:0]  item_q;
	msg_t        msg_q;
	rec_t        rec_q;
	logic        rec_valid_q;

	logic [31:0]          begin_eff;
	logic [32:0]          end_sum;
	logic                 load_item;
	logic [31:0]          item_value;
	logic [3:0]           bin_sel;
	logic [3:0]           msg_kind;
	logic                 cfg_write;
	dst_ctrl_t            dst_ctrl;
	logic                 ac_busy;
	logic                 nat_busy;
	logic [AC_CNT_W-1:0]  ac_count;
	logic [NAT_CNT_W-1:0] nat_count;

	// configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2:2] == REG_WINDOW_LENGTH);
	assign prdata    = (paddr[2:2] == REG_WINDOW_LENGTH) ? window_length_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RESET;
		end else if (cfg_write) begin
			window_length_q <= pwdata;
		end
	end

	// window end with a carry bit
	assign begin_eff = open_q ? begin_q : msg_q.msg_time;
	assign end_sum   = {1'b0, begin_eff} + {1'b0, window_length_q};

	// record item value
	assign bin_sel = item_q - 4'd1;
	always_comb begin
		priority if (item_q == KIND_TOTAL) begin
			item_value = total_q;
		end else if (item_q == KIND_AIRCRAFT) begin
			item_value = 32'(ac_count);
		end else if (item_q == KIND_NATIONS) begin
			item_value = 32'(nat_count);
		end else begin
			item_value = bins_q[bin_sel];
		end
	end

	assign load_item = (state_q == ST_EMIT) && (!rec_valid_q || rec_ch.ready);
	assign msg_kind  = format_kind(msg_q.downlink_format);

	assign dst_ctrl.start = (state_q == ST_COUNT);
	assign dst_ctrl.clear = load_item && (item_q == KIND_NATIONS);

	assign msg_ch.ready = (state_q == ST_IDLE);

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			open_q      <= 1'b0;
			begin_q     <= '0;
			total_q     <= '0;
			item_q      <= KIND_TOTAL;
			rec_valid_q <= 1'b0;
			for (int i = 0; i < FORMAT_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			if (load_item) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ch.ready) begin
				rec_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_ch.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					begin_q <= begin_eff;
					open_q  <= 1'b1;
					item_q  <= KIND_TOTAL;
					if ({1'b0, msg_q.msg_time} < end_sum) begin
						state_q <= ST_COUNT;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_item) begin
						if (item_q == KIND_NATIONS) begin
							begin_q <= end_q;
							total_q <= '0;
							for (int i = 0; i < FORMAT_BINS; i++) begin
								bins_q[i] <= '0;
							end
							state_q <= ST_COUNT;
						end else begin
							item_q <= item_q + 4'd1;
						end
					end
				end
				ST_COUNT: begin
					total_q <= total_q + 32'd1;
					for (int i = 0; i < FORMAT_BINS; i++) begin
						if (msg_kind == 4'(i + 1)) begin
							bins_q[i] <= bins_q[i] + 32'd1;
						end
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!ac_busy && !nat_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (msg_ch.valid && msg_ch.ready) begin
			msg_q <= msg_ch.payload;
		end
		if (state_q == ST_CHECK) begin
			end_q <= end_sum[31:0];
		end
		if (load_item) begin
			rec_q.window_start <= begin_q;
			rec_q.item_kind    <= item_q;
			rec_q.count_value  <= item_value;
			rec_q.last_item    <= (item_q == KIND_NATIONS);
		end
	end

	assign rec_ch.valid   = rec_valid_q;
	assign rec_ch.payload = rec_q;

	// distinct tables
	wms_distinct #(
		.SLOTS (AIRCRAFT_SLOTS),
		.WIDTH (24)
	) u_aircraft (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dst_ctrl),
		.value  (msg_q.aircraft_address),
		.busy   (ac_busy),
		.count  (ac_count)
	);

	wms_distinct #(
		.SLOTS (NATION_SLOTS),
		.WIDTH (8)
	) u_nation (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dst_ctrl),
		.value  (msg_q.nation_id),
		.busy   (nat_busy),
		.count  (nat_count)
	);

endmodule

// ===== rtl/wms_distinct.sv =====
// Distinct-value table: linear search over the stored entries, one read a cycle,
// append on a miss while there is room.
module wms_distinct #(
	parameter int SLOTS = 256,
	parameter int WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wms_pkg::dst_ctrl_t           ctrl,
	input  logic [WIDTH-1:0]             value,
	output logic                         busy,
	output logic [$clog2(SLOTS+1)-1:0]   count
);
	import wms_pkg::*;

	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [WIDTH-1:0] mem [SLOTS];
	logic [WIDTH-1:0] rdata_s1;
	logic [WIDTH-1:0] value_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic             busy_q;
	logic             rd_s1;

	logic issue;
	logic hit;
	logic miss_done;
	logic room;

	// search control
	assign issue     = busy_q && (idx_q < count_q);
	assign hit       = rd_s1 && (rdata_s1 == value_q);
	assign miss_done = busy_q && !rd_s1 && !(idx_q < count_q);
	assign room      = count_q < CNT_W'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			rd_s1   <= 1'b0;
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.clear) begin
				count_q <= '0;
			end
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rd_s1  <= 1'b0;
				idx_q  <= '0;
			end else if (busy_q) begin
				rd_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (hit) begin
					busy_q <= 1'b0;
					rd_s1  <= 1'b0;
				end else if (miss_done) begin
					busy_q <= 1'b0;
					if (room) begin
						count_q <= count_q + 1'b1;
					end
				end
			end
		end
	end

	// value under search
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			value_q <= value;
		end
	end

	// table memory: one write or one read per cycle, registered read data
	always_ff @(posedge clk) begin
		if (!ctrl.start && miss_done && !hit && room) begin
			mem[count_q[ADDR_W-1:0]] <= value_q;
		end
		if (issue) begin
			rdata_s1 <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	assign busy  = busy_q;
	assign count = count_q;

endmodule
